[design/rfp_pkg.sv]
`timescale 1ns / 1ps

package rfp_pkg;

    localparam int FRAME_CAPACITY = 64;
    localparam int MAX_EPC_BYTES  = 32;

    localparam int CNT_W     = $clog2(FRAME_CAPACITY + 1);
    localparam int ADDR_W    = $clog2(FRAME_CAPACITY);
    localparam int EPC_LEN_W = 6;
    localparam int IDX_W     = 5;
    localparam int SUM_W     = EPC_LEN_W + 1;
    localparam int CMP_W     = 8;

    localparam logic [7:0] HEAD_BYTE   = 8'hBB;
    localparam logic [7:0] TAIL_BYTE   = 8'h7E;
    localparam logic [7:0] NOTICE_TYPE = 8'h02;
    localparam logic [7:0] NOTICE_CMD  = 8'h22;

    localparam int MIN_FRAME_LEN = 10;
    localparam int EPC_OVERHEAD  = 13;
    localparam int EPC_OFFSET    = 7;
    localparam int TYPE_OFFSET   = 1;
    localparam int CMD_OFFSET    = 2;
    localparam int RSSI_OFFSET   = 4;

    typedef enum logic [1:0] {
        KIND_EPC     = 2'd0,
        KIND_VALID   = 2'd1,
        KIND_INVALID = 2'd2,
        KIND_BAD_TAG = 2'd3
    } t_kind;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    typedef struct packed {
        t_kind                kind;
        logic [EPC_LEN_W-1:0] epc_len;
        logic signed [7:0]    rssi;
    } t_cmd;

    typedef struct packed {
        t_kind                kind;
        logic [7:0]           epc_byte;
        logic [IDX_W-1:0]     epc_index;
        logic [EPC_LEN_W-1:0] epc_length;
        logic signed [7:0]    rssi_dbm;
        logic                 last;
    } t_result;

endpackage

[design/rfid_reply_frame_parser.sv]
`timescale 1ns / 1ps
// events: a tail or overflow byte that gives one event shows it in the cycle after its transfer;
//   a tag notice passes through states S_RD and S_LOAD before its first epc byte shows in S_OUT
// throughput: one byte per cycle while the emitter is idle; each epc byte goes through the
//   single frame store read port in states S_RD, S_LOAD and S_OUT, and S_OUT holds on an
//   output stall; input waits until the last result of a frame is taken
// reset: synchronous active low, returns to head hunting; the frame store is not cleared

module rfid_reply_frame_parser
    import rfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] epc_byte, [12:8] epc_index,
                                        // [18:13] epc_length, [26:19] rssi_dbm, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
    output logic        m_axis_tlast    // last_of_run
);

    logic             r_in_frame;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_type;
    logic [7:0]       r_cmd;
    logic [7:0]       r_rssi;

    logic             busy;
    logic             accept;
    logic             overflow;
    logic             is_tail;
    logic [CNT_W-1:0] frame_len;
    logic [CMP_W-1:0] epc_full;
    t_wr_req          wr;
    logic             cmd_valid;
    t_cmd             cmd;
    logic             res_valid;
    t_result          res;

    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign overflow      = (r_count >= CNT_W'(FRAME_CAPACITY));
    assign is_tail       = (s_axis_tdata == TAIL_BYTE);
    assign frame_len     = r_count + CNT_W'(1);
    assign epc_full      = CMP_W'(frame_len) - CMP_W'(EPC_OVERHEAD);

    always_comb begin
        wr.en   = accept && (r_in_frame ? !overflow : (s_axis_tdata == HEAD_BYTE));
        wr.addr = r_in_frame ? r_count[ADDR_W-1:0] : '0;
        wr.data = s_axis_tdata;

        cmd_valid   = accept && r_in_frame && (overflow || is_tail);
        cmd.kind    = KIND_VALID;
        cmd.epc_len = EPC_LEN_W'(epc_full);
        cmd.rssi    = $signed(r_rssi);
        if (overflow || frame_len < CNT_W'(MIN_FRAME_LEN)) begin
            cmd.kind = KIND_INVALID;
        end else if (r_type != NOTICE_TYPE || r_cmd != NOTICE_CMD) begin
            cmd.kind = KIND_VALID;
        end else if (CMP_W'(frame_len) <= CMP_W'(EPC_OVERHEAD)
                     || epc_full > CMP_W'(MAX_EPC_BYTES)) begin
            cmd.kind = KIND_BAD_TAG;
        end else begin
            cmd.kind = KIND_EPC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
        end else if (accept) begin
            if (!r_in_frame) begin
                if (s_axis_tdata == HEAD_BYTE) begin
                    r_in_frame <= 1'b1;
                    r_count    <= CNT_W'(1);
                end
            end else if (overflow || is_tail) begin
                r_in_frame <= 1'b0;
                r_count    <= '0;
            end else begin
                r_count <= frame_len;
            end
        end
    end

    // header bytes kept aside for the judgment at the tail
    always_ff @(posedge i_clk) begin
        if (accept && r_in_frame && !overflow) begin
            if (r_count == CNT_W'(TYPE_OFFSET)) begin
                r_type <= s_axis_tdata;
            end
            if (r_count == CNT_W'(CMD_OFFSET)) begin
                r_cmd <= s_axis_tdata;
            end
            if (r_count == CNT_W'(RSSI_OFFSET)) begin
                r_rssi <= s_axis_tdata;
            end
        end
    end

    rfp_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tuser  = res.kind;
    assign m_axis_tlast  = res.last;
    assign m_axis_tdata  = {5'b0, $unsigned(res.rssi_dbm), res.epc_length,
                            res.epc_index, res.epc_byte};

endmodule

[design/rfp_emit.sv]
`timescale 1ns / 1ps

module rfp_emit
    import rfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_wr_req i_wr,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_busy,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_LOAD,
        S_OUT
    } t_state;

    logic [7:0]           r_mem [FRAME_CAPACITY];
    logic [7:0]           r_rd_data;
    logic [ADDR_W-1:0]    rd_addr;
    logic [SUM_W-1:0]     addr_sum;

    t_state               r_state;
    logic [EPC_LEN_W-1:0] r_idx;
    logic [EPC_LEN_W-1:0] r_len;
    logic signed [7:0]    r_rssi;
    t_result              r_res;

    // frame store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign addr_sum = SUM_W'(r_idx) + SUM_W'(EPC_OFFSET);
    assign rd_addr  = ADDR_W'(addr_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.kind == KIND_EPC) begin
                            r_len   <= i_cmd.epc_len;
                            r_rssi  <= i_cmd.rssi;
                            r_idx   <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_res.kind       <= i_cmd.kind;
                            r_res.epc_byte   <= '0;
                            r_res.epc_index  <= '0;
                            r_res.epc_length <= '0;
                            r_res.rssi_dbm   <= '0;
                            r_res.last       <= 1'b1;
                            r_state          <= S_OUT;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_res.kind       <= KIND_EPC;
                    r_res.epc_byte   <= r_rd_data;
                    r_res.epc_index  <= r_idx[IDX_W-1:0];
                    r_res.epc_length <= r_len;
                    r_res.rssi_dbm   <= r_rssi;
                    r_res.last       <= (r_idx == r_len - EPC_LEN_W'(1));
                    r_state          <= S_OUT;
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        if (r_res.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + EPC_LEN_W'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;

endmodule

[design/rfp_checker.sv]
`timescale 1ns / 1ps

module rfp_checker
    import rfp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic [IDX_W-1:0]     chk_index;
    logic [EPC_LEN_W-1:0] chk_length;

    assign chk_index  = m_axis_tdata[12:8];
    assign chk_length = m_axis_tdata[18:13];

    // no input transfer while a result is pending
    a_no_input_while_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result is pending");

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_single_event_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_EPC) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("single event not last or carries data");

    a_epc_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_EPC)
            |-> (chk_length != '0 && EPC_LEN_W'(chk_index) < chk_length))
        else $error("epc index outside epc length");

    a_output_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
                 && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind rfid_reply_frame_parser rfp_checker u_rfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import rfp_pkg::*;

    localparam int LIMIT = 400000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // [7:0] epc_byte, [12:8] epc_index,
                                          // [18:13] epc_length, [26:19] rssi_dbm
    logic [1:0]  m_axis_tuser;            // [1:0] event_kind
    logic        m_axis_tlast;            // last_of_run

    logic [7:0]  rx_bytes_q[$];
    t_result     events_q[$];

    logic        rx_in_frame = 1'b0;
    int          rx_count    = 0;
    logic [7:0]  rx_frame[FRAME_CAPACITY];

    int          cyc          = 0;
    int          mismatch_cnt = 0;
    int          burst_left;
    int          gap_left;
    int          frame_bytes;

    rfid_reply_frame_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // frame parser prediction
    task automatic push_event(t_kind kind, logic [7:0] epc_b, int idx, int len,
                              logic [7:0] rssi, logic last);
        t_result ev;
        ev.kind       = kind;
        ev.epc_byte   = epc_b;
        ev.epc_index  = idx[IDX_W-1:0];
        ev.epc_length = len[EPC_LEN_W-1:0];
        ev.rssi_dbm   = rssi;
        ev.last       = last;
        events_q.push_back(ev);
    endtask

    task automatic judge_frame();
        int len;
        int epc_len;
        len = rx_count;
        if (len < MIN_FRAME_LEN) begin
            push_event(KIND_INVALID, 8'h00, 0, 0, 8'h00, 1'b1);
        end else if (rx_frame[TYPE_OFFSET] != NOTICE_TYPE
                     || rx_frame[CMD_OFFSET] != NOTICE_CMD) begin
            push_event(KIND_VALID, 8'h00, 0, 0, 8'h00, 1'b1);
        end else if (len <= EPC_OVERHEAD || len - EPC_OVERHEAD > MAX_EPC_BYTES) begin
            push_event(KIND_BAD_TAG, 8'h00, 0, 0, 8'h00, 1'b1);
        end else begin
            epc_len = len - EPC_OVERHEAD;
            for (int i = 0; i < epc_len; i++) begin
                push_event(KIND_EPC, rx_frame[EPC_OFFSET + i], i, epc_len,
                           rx_frame[RSSI_OFFSET], (i + 1 == epc_len));
            end
        end
    endtask

    task automatic predict_byte(logic [7:0] b);
        if (!rx_in_frame) begin
            if (b == HEAD_BYTE) begin
                rx_in_frame = 1'b1;
                rx_frame[0] = b;
                rx_count    = 1;
            end
        end else if (rx_count >= FRAME_CAPACITY) begin
            rx_in_frame = 1'b0;
            rx_count    = 0;
            push_event(KIND_INVALID, 8'h00, 0, 0, 8'h00, 1'b1);
        end else begin
            rx_frame[rx_count] = b;
            rx_count++;
            if (b == TAIL_BYTE) begin
                judge_frame();
                rx_in_frame = 1'b0;
                rx_count    = 0;
            end
        end
    endtask

    // stimulus helpers
    function automatic logic [7:0] body_byte();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (v == TAIL_BYTE) v = 8'hFF;
        return v;
    endfunction

    task automatic push_frame(int len, logic [7:0] b1, logic [7:0] b2, logic [7:0] rssi);
        logic [7:0] v;
        rx_bytes_q.push_back(HEAD_BYTE);
        for (int i = 1; i < len - 1; i++) begin
            v = body_byte();
            if (i == TYPE_OFFSET) v = b1;
            else if (i == CMD_OFFSET) v = b2;
            else if (i == RSSI_OFFSET) v = rssi;
            rx_bytes_q.push_back(v);
        end
        rx_bytes_q.push_back(TAIL_BYTE);
        frame_bytes += len;
    endtask

    task automatic push_overflow(logic [7:0] extra);
        rx_bytes_q.push_back(HEAD_BYTE);
        for (int i = 1; i < FRAME_CAPACITY; i++) rx_bytes_q.push_back(body_byte());
        rx_bytes_q.push_back(extra);
        frame_bytes += FRAME_CAPACITY + 1;
    endtask

    task automatic push_noise(int n);
        logic [7:0] v;
        for (int i = 0; i < n; i++) begin
            v = 8'($urandom_range(0, 255));
            if (v == HEAD_BYTE) v = 8'hBA;
            rx_bytes_q.push_back(v);
        end
    endtask

    // driver: bursts with random gaps
    always @(posedge i_clk) begin : drv
        logic       nv;
        logic [7:0] nd;
        logic       taken;
        nv    = s_axis_tvalid;
        nd    = s_axis_tdata;
        taken = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            nv         = 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            if (taken) predict_byte(s_axis_tdata);
            if (!s_axis_tvalid || taken) begin
                nv = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (rx_bytes_q.size() > 0) begin
                    nv = 1'b1;
                    nd = rx_bytes_q.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata  <= nd;
    end

    // monitor with its own stall pattern
    always @(posedge i_clk) begin : mon
        t_result want;
        logic    rdy;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (events_q.size() == 0) begin
                $error("unexpected transfer: event_kind %0d", m_axis_tuser);
                mismatch_cnt++;
            end else begin
                want = events_q.pop_front();
                if (m_axis_tuser != want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    mismatch_cnt++;
                end
                if (m_axis_tdata[7:0] != want.epc_byte) begin
                    $error("epc_byte: expected %0h, got %0h", want.epc_byte, m_axis_tdata[7:0]);
                    mismatch_cnt++;
                end
                if (m_axis_tdata[12:8] != want.epc_index) begin
                    $error("epc_index: expected %0d, got %0d", want.epc_index,
                           m_axis_tdata[12:8]);
                    mismatch_cnt++;
                end
                if (m_axis_tdata[18:13] != want.epc_length) begin
                    $error("epc_length: expected %0d, got %0d", want.epc_length,
                           m_axis_tdata[18:13]);
                    mismatch_cnt++;
                end
                if ($signed(m_axis_tdata[26:19]) != want.rssi_dbm) begin
                    $error("rssi_dbm: expected %0d, got %0d", want.rssi_dbm,
                           $signed(m_axis_tdata[26:19]));
                    mismatch_cnt++;
                end
                if (m_axis_tlast != want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, m_axis_tlast);
                    mismatch_cnt++;
                end
            end
        end
        case (cyc[9:8])
            2'd0:    rdy = 1'b1;
            2'd1:    rdy = 1'($urandom_range(0, 1));
            2'd2:    rdy = ($urandom_range(0, 3) == 0);
            default: rdy = cyc[4];
        endcase
        m_axis_tready <= rdy;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT) begin
            $display("[rfid_reply_frame_parser] ERROR");
            $finish;
        end
    end

    initial begin
        int pick;
        int epc_len;
        frame_bytes = 0;

        // directed frames
        rx_bytes_q.push_back(8'h00);
        rx_bytes_q.push_back(8'hFF);
        rx_bytes_q.push_back(TAIL_BYTE);
        rx_bytes_q.push_back(NOTICE_TYPE);
        push_frame(2, 8'h00, 8'h00, 8'h00);
        push_frame(MIN_FRAME_LEN - 1, NOTICE_TYPE, NOTICE_CMD, 8'h80);
        push_frame(MIN_FRAME_LEN, 8'h01, NOTICE_CMD, 8'h00);
        push_frame(12, HEAD_BYTE, HEAD_BYTE, HEAD_BYTE);
        push_frame(EPC_OVERHEAD, NOTICE_TYPE, NOTICE_CMD, 8'hC0);
        push_frame(EPC_OVERHEAD + 1, NOTICE_TYPE, NOTICE_CMD, 8'h80);
        push_frame(EPC_OVERHEAD + MAX_EPC_BYTES, NOTICE_TYPE, NOTICE_CMD, 8'hFF);
        push_overflow(TAIL_BYTE);

        // random frames, mostly well-formed tag notices
        while (frame_bytes < 185) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                epc_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_EPC_BYTES)
                                                      : $urandom_range(1, 8);
                push_frame(epc_len + EPC_OVERHEAD, NOTICE_TYPE, NOTICE_CMD, body_byte());
            end else if (pick < 75) begin
                push_frame($urandom_range(MIN_FRAME_LEN, 30), body_byte(),
                           ($urandom_range(0, 1) == 0) ? NOTICE_CMD : body_byte(), body_byte());
            end else if (pick < 83) begin
                push_frame(($urandom_range(0, 1) == 0)
                           ? $urandom_range(MIN_FRAME_LEN, EPC_OVERHEAD)
                           : $urandom_range(EPC_OVERHEAD + MAX_EPC_BYTES + 1, FRAME_CAPACITY),
                           NOTICE_TYPE, NOTICE_CMD, body_byte());
            end else if (pick < 89) begin
                push_frame($urandom_range(2, MIN_FRAME_LEN - 1), NOTICE_TYPE, NOTICE_CMD,
                           body_byte());
            end else if (pick < 94) begin
                push_overflow(($urandom_range(0, 1) == 0) ? TAIL_BYTE : body_byte());
            end else begin
                push_noise($urandom_range(1, 4));
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_bytes_q.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (events_q.size() > 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatch_cnt == 0 && events_q.size() == 0) begin
            $display("[rfid_reply_frame_parser] OK");
        end else begin
            $display("[rfid_reply_frame_parser] ERROR");
        end
        $finish;
    end

endmodule
